FILE: rtl/fcct_pkg.sv
// Shared types, codes and helper functions for the cluster chain table core.
// Used by fcct_ctrl, fcct_dp and fat_cluster_chain_table_core; no dependencies.
`timescale 1ns / 1ps

package fcct_pkg;

  // Default table depth (entries)
  localparam int TABLE_ENTRIES_DEF = 4096;

  // Field widths fixed by the transaction format
  localparam int OP_W      = 2;
  localparam int CLUSTER_W = 12;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 13;
  localparam int STAT_W    = 2;
  localparam int FTYPE_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_TYPE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b1;

  // Table formats
  localparam logic [FTYPE_W-1:0] FT_FAT12 = 2'd0;
  localparam logic [FTYPE_W-1:0] FT_FAT16 = 2'd1;
  localparam logic [FTYPE_W-1:0] FT_FAT32 = 2'd2;

  localparam logic [FTYPE_W-1:0] FAT_TYPE_RST    = FT_FAT16;
  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 13'd4096;

  localparam logic [VALUE_W-1:0] END_MARK = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_EXTEND = 2'd2,
    OP_COUNT  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_UNSUP  = 2'd2,
    STAT_RANGE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LINK,
    S_SCAN,
    S_ALLOC,
    S_LINKUP
  } state_t;

  // What goes into the result register
  typedef enum logic [2:0] {
    RK_RANGE,
    RK_UNSUP,
    RK_FULL,
    RK_DONE,
    RK_LINK,
    RK_PICK,
    RK_COUNT
  } res_kind_t;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [CLUSTER_W-1:0] cluster;
    logic [VALUE_W-1:0]   entry_value;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] next_cluster;
    logic [COUNT_W-1:0] free_count;
    logic [STAT_W-1:0]  status;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic      accept;
    logic      rd_cluster;
    logic      scan_start;
    logic      scan_step;
    logic      wr_entry;
    logic      wr_pick;
    logic      wr_link;
    logic      res_load;
    res_kind_t res_kind;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic range_err;
    logic fat12;
    logic link_end;
    logic hit;
    logic scan_done;
  } dp_stat_t;

  // Entry width mask of the active format; unused code acts as FAT12
  function automatic logic [VALUE_W-1:0] width_mask(input logic [FTYPE_W-1:0] ft);
    logic [VALUE_W-1:0] m;
    case (ft)
      FT_FAT16: m = 32'h0000_FFFF;
      FT_FAT32: m = 32'h0FFF_FFFF;
      default:  m = 32'h0000_0FFF;
    endcase
    return m;
  endfunction

  // Lowest end-of-chain code of the active format
  function automatic logic [VALUE_W-1:0] end_low(input logic [FTYPE_W-1:0] ft);
    logic [VALUE_W-1:0] lo;
    case (ft)
      FT_FAT16: lo = 32'h0000_FFF8;
      FT_FAT32: lo = 32'h0FFF_FFF8;
      default:  lo = 32'h0000_0FF8;
    endcase
    return lo;
  endfunction

endpackage

FILE: rtl/fat_cluster_chain_table_core.sv
// Top level of the cluster chain table core: controller plus datapath.
// Depends on fcct_pkg, fcct_ctrl and fcct_dp.
//
//   channel  | ports                          | transfer
//   ---------+--------------------------------+-----------------------------
//   input    | start, busy, in_data           | start high while busy low
//   result   | out_valid, out_data            | one-cycle strobe, no stall
//   config   | cfg_we, cfg_index, cfg_wdata   | write when cfg_we high
//
// A write or an out-of-range request is answered from the decode state; a read, an
// extend along a link and a FAT12 extend at chain end read the entry first. Count
// free scans the entries in use. Extend at chain end scans one entry per cycle
// through the single read port, then on allocation writes the new chain end and the
// link to it. Synchronous active-low reset; the table is not cleared and must be
// loaded by write operations.
`timescale 1ns / 1ps

module fat_cluster_chain_table_core #(
  parameter int TableEntries = fcct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  fcct_pkg::in_t                   in_data,
  output logic                            out_valid,
  output fcct_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [fcct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcct_pkg::CFG_DW-1:0]     cfg_wdata
);
  import fcct_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequence each transaction
  fcct_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Hold the table and build results
  fcct_dp #(
    .TableEntries (TableEntries)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/fcct_dp.sv
// Datapath: configuration registers, table memory, free-entry scan and result register.
// Depends on fcct_pkg; driven by commands from fcct_ctrl.
`timescale 1ns / 1ps

module fcct_dp #(
  parameter int TableEntries = fcct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fcct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcct_pkg::CFG_DW-1:0]         cfg_wdata,
  input  fcct_pkg::in_t                       in_data,
  input  fcct_pkg::ctl_cmd_t                  cmd,
  output fcct_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  output fcct_pkg::out_t                      out_data
);
  import fcct_pkg::*;

  localparam int AW = $clog2(TableEntries);
  localparam int UW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
  localparam logic [UW-1:0] TE_U = UW'(TableEntries);
  localparam logic [UW-1:0] SCAN_FIRST = UW'(2);

  logic [FTYPE_W-1:0]   fat_type_r;
  logic [COUNT_W-1:0]   entry_count_r;
  logic [OP_W-1:0]      op_r;
  logic [CLUSTER_W-1:0] cluster_r;
  logic [VALUE_W-1:0]   value_r;

  logic [VALUE_W-1:0]   mem [TableEntries];
  logic [VALUE_W-1:0]   rdata_r;

  logic [UW-1:0]        issue_r;
  logic                 pend_r;
  logic [AW-1:0]        pend_idx_r;
  logic [AW-1:0]        pick_r;
  logic [COUNT_W-1:0]   count_r;

  logic                 out_valid_r;
  out_t                 out_r;
  out_t                 res_nxt;

  logic [VALUE_W-1:0]   mask;
  logic [VALUE_W-1:0]   masked;
  logic                 link_end;
  logic [VALUE_W-1:0]   link;
  logic [UW-1:0]        used;
  logic                 issue_ok;
  logic                 hit;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [VALUE_W-1:0]   wr_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat_type_r    <= FAT_TYPE_RST;
      entry_count_r <= ENTRY_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FAT_TYPE:    fat_type_r    <= cfg_wdata[FTYPE_W-1:0];
        CFG_ENTRY_COUNT: entry_count_r <= cfg_wdata[COUNT_W-1:0];
        default:         ;
      endcase
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_data.operation;
      cluster_r <= in_data.cluster;
      value_r   <= in_data.entry_value;
    end
  end

  // Entries in use, saturated at the table depth
  always_comb begin
    if (UW'(entry_count_r) > TE_U) begin
      used = TE_U;
    end else begin
      used = UW'(entry_count_r);
    end
  end

  assign mask     = width_mask(fat_type_r);
  assign masked   = rdata_r & mask;
  assign link_end = (masked >= end_low(fat_type_r));
  assign link     = link_end ? END_MARK : masked;
  assign issue_ok = (issue_r < used);
  assign hit      = pend_r && (masked == '0);

  // Read port: the addressed cluster, or the next scan index
  assign rd_en   = cmd.rd_cluster || (cmd.scan_step && issue_ok);
  assign rd_addr = cmd.rd_cluster ? AW'(cluster_r) : issue_r[AW-1:0];

  // Write port: a loaded entry, a new chain end, or the link to it
  always_comb begin
    wr_en   = cmd.wr_entry || cmd.wr_pick || cmd.wr_link;
    wr_addr = AW'(cluster_r);
    wr_data = value_r & mask;
    if (cmd.wr_pick) begin
      wr_addr = pick_r;
      wr_data = END_MARK & mask;
    end else if (cmd.wr_link) begin
      wr_data = VALUE_W'(pick_r) & mask;
    end
  end

  // Table memory with registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Free-entry scan: one read issued and one entry checked per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (cmd.scan_start) begin
      pend_r <= 1'b0;
    end else if (cmd.scan_step) begin
      pend_r <= issue_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      issue_r <= SCAN_FIRST;
      count_r <= '0;
    end else if (cmd.scan_step) begin
      pend_idx_r <= issue_r[AW-1:0];
      if (issue_ok) begin
        issue_r <= issue_r + UW'(1);
      end
      if (hit) begin
        pick_r  <= pend_idx_r;
        count_r <= count_r + COUNT_W'(1);
      end
    end
  end

  // Result register; the strobe lasts one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_load;
    end
  end

  // Build the result of the finishing transaction
  always_comb begin
    res_nxt        = '0;
    res_nxt.status = STAT_OK;
    case (cmd.res_kind)
      RK_RANGE: res_nxt.status       = STAT_RANGE;
      RK_UNSUP: res_nxt.status       = STAT_UNSUP;
      RK_FULL:  res_nxt.status       = STAT_FULL;
      RK_LINK:  res_nxt.next_cluster = link;
      RK_PICK:  res_nxt.next_cluster = VALUE_W'(pick_r);
      RK_COUNT: res_nxt.free_count   = count_r;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r <= res_nxt;
    end
  end

  // Status toward the controller
  always_comb begin
    stat.op        = op_t'(op_r);
    stat.range_err = (UW'(cluster_r) >= used);
    stat.fat12     = !((fat_type_r == FT_FAT16) || (fat_type_r == FT_FAT32));
    stat.link_end  = link_end;
    stat.hit       = hit;
    stat.scan_done = !pend_r && !issue_ok;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/fcct_ctrl.sv
// Controller state machine: sequences decode, table reads, scan and writes.
// Depends on fcct_pkg; commands fcct_dp and reads its status.
`timescale 1ns / 1ps

module fcct_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fcct_pkg::dp_stat_t  stat,
  output fcct_pkg::ctl_cmd_t  cmd
);
  import fcct_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_kind = RK_DONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.op == OP_COUNT) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else if (stat.range_err) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_RANGE;
          state_nxt    = S_IDLE;
        end else if (stat.op == OP_WRITE) begin
          cmd.res_load = 1'b1;
          if (stat.fat12) begin
            cmd.res_kind = RK_UNSUP;
          end else begin
            cmd.wr_entry = 1'b1;
            cmd.res_kind = RK_DONE;
          end
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_cluster = 1'b1;
          state_nxt      = S_LINK;
        end
      end
      S_LINK: begin
        if (stat.op == OP_READ || !stat.link_end) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_LINK;
          state_nxt    = S_IDLE;
        end else if (stat.fat12) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_UNSUP;
          state_nxt    = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.op == OP_EXTEND && stat.hit) begin
          state_nxt = S_ALLOC;
        end else if (stat.scan_done) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = (stat.op == OP_COUNT) ? RK_COUNT : RK_FULL;
          state_nxt    = S_IDLE;
        end
      end
      S_ALLOC: begin
        cmd.wr_pick = 1'b1;
        state_nxt   = S_LINKUP;
      end
      S_LINKUP: begin
        cmd.wr_link  = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_kind = RK_PICK;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: bench/fcct_chain_checker.sv
// Checker for the cluster chain table core: watches the command, result and
// register ports, predicts each result and compares it field by field.
// Depends on fcct_pkg only.
`timescale 1ns / 1ps

module fcct_chain_checker #(
  parameter int TableDepth = fcct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  fcct_pkg::in_t                  in_data,
  input  logic                           out_valid,
  input  fcct_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [fcct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcct_pkg::CFG_DW-1:0]    cfg_wdata,
  output int unsigned                    errors,
  output int unsigned                    pending
);
  import fcct_pkg::*;

  // Shadow of the table and of both registers
  logic [VALUE_W-1:0] chain_table [TableDepth];
  logic [FTYPE_W-1:0] cur_type;
  logic [COUNT_W-1:0] cur_count;

  out_t        expected_results[$];
  int unsigned fails;
  int unsigned shown;

  initial begin
    fails = 0;
    shown = 0;
  end

  // Significant bits of one entry in the active format
  function automatic int unsigned entry_bits();
    if (cur_type == FT_FAT16) return 16;
    if (cur_type == FT_FAT32) return 28;
    return 12;
  endfunction

  function automatic logic [VALUE_W-1:0] entry_mask();
    return (32'd1 << entry_bits()) - 32'd1;
  endfunction

  // Link stored in an entry; the top eight codes of the format end the chain
  function automatic logic [VALUE_W-1:0] follow_link(input logic [CLUSTER_W-1:0] idx);
    logic [VALUE_W-1:0] m;
    logic [VALUE_W-1:0] v;
    m = entry_mask();
    v = chain_table[idx] & m;
    return (v >= m - 32'd7) ? END_MARK : v;
  endfunction

  // Apply one transaction to the shadow table and return its result
  function automatic out_t apply_op(input in_t t);
    out_t               r;
    op_t                op;
    logic [VALUE_W-1:0] m;
    logic [VALUE_W-1:0] link;
    int unsigned        used;
    int unsigned        i;
    int unsigned        nfree;
    int unsigned        pick;
    bit                 found;
    bit                 fat12;
    r     = '0;
    op    = op_t'(t.operation);
    m     = entry_mask();
    used  = (cur_count > TableDepth) ? TableDepth : cur_count;
    fat12 = (cur_type != FT_FAT16) && (cur_type != FT_FAT32);
    nfree = 0;
    if (op == OP_COUNT) begin
      // Reserved entries 0 and 1 never count as free
      for (i = 2; i < used; i++)
        if ((chain_table[i] & m) == '0) nfree++;
      r.free_count = COUNT_W'(nfree);
    end else if (t.cluster >= used) begin
      r.status = STAT_RANGE;
    end else if (op == OP_READ) begin
      r.next_cluster = follow_link(t.cluster);
    end else if (op == OP_WRITE) begin
      if (fat12) r.status = STAT_UNSUP;
      else chain_table[t.cluster] = t.entry_value & m;
    end else begin
      link = follow_link(t.cluster);
      if (link != END_MARK) begin
        r.next_cluster = link;
      end else if (fat12) begin
        r.status = STAT_UNSUP;
      end else begin
        // Take the lowest free entry, mark it as chain end and link it in
        found = 0;
        pick  = 0;
        for (i = 2; i < used && !found; i++) begin
          if ((chain_table[i] & m) == '0) begin
            found = 1;
            pick  = i;
          end
        end
        if (!found) begin
          r.status = STAT_FULL;
        end else begin
          chain_table[pick]      = END_MARK & m;
          chain_table[t.cluster] = VALUE_W'(pick) & m;
          r.next_cluster         = VALUE_W'(pick);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    bit   bad;
    if (!rst_n) begin
      cur_type  = FAT_TYPE_RST;
      cur_count = ENTRY_COUNT_RST;
      expected_results.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        if (cfg_index == CFG_FAT_TYPE) cur_type = cfg_wdata[FTYPE_W-1:0];
        else if (cfg_index == CFG_ENTRY_COUNT) cur_count = cfg_wdata[COUNT_W-1:0];
      end
      // Compare a strobed result with the oldest prediction
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          fails++;
          if (shown < 10) begin
            shown++;
            $display("%0t: unexpected result next %h free %0d status %0d", $realtime,
                     out_data.next_cluster, out_data.free_count, out_data.status);
          end
        end else begin
          want = expected_results.pop_front();
          bad  = (out_data.next_cluster !== want.next_cluster) ||
                 (out_data.free_count !== want.free_count) ||
                 (out_data.status !== want.status);
          if (bad) begin
            fails++;
            if (shown < 10) begin
              shown++;
              $display({"%0t: mismatch expected next %h free %0d status %0d, ",
                        "got next %h free %0d status %0d"},
                       $realtime, want.next_cluster, want.free_count, want.status,
                       out_data.next_cluster, out_data.free_count, out_data.status);
            end
          end
        end
      end
      // Predict each accepted transaction
      if (start && !busy) expected_results.push_back(apply_op(in_data));
    end
    pending <= expected_results.size();
    errors  <= fails;
  end

endmodule

FILE: bench/fat_cluster_chain_table_core_tb.sv
// Top of the cluster chain table bench: clock, reset, table load, directed and
// random transactions over several formats and sizes, verdict.
// Depends on fcct_pkg, fat_cluster_chain_table_core and fcct_chain_checker.
`timescale 1ns / 1ps

module fat_cluster_chain_table_core_tb;
  import fcct_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 16;
  localparam int LOAD_ENTRIES = 256;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  in_t                  in_data   = '0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_wdata = '0;
  logic                 busy;
  logic                 out_valid;
  out_t                 out_data;
  int unsigned          errors;
  int unsigned          pending;
  int unsigned          quiet_cycles = 0;

  // Stimulus view of the active setting
  int unsigned        cur_used = TABLE_ENTRIES_DEF;
  bit                 allow_gaps = 1;

  fat_cluster_chain_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fcct_chain_checker u_chain_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always #10 clk = ~clk;

  // Stop when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold one transaction until accepted, then maybe drop start for a burst
  task automatic send(input op_t op, input logic [CLUSTER_W-1:0] cl,
                      input logic [VALUE_W-1:0] val);
    in_data <= '{operation: op, cluster: cl, entry_value: val};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every result is in and the core is free
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // Write both registers while idle
  task automatic set_format(input logic [FTYPE_W-1:0] ft, input int unsigned cnt);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FAT_TYPE;
    cfg_wdata <= CFG_DW'(ft);
    @(posedge clk);
    cfg_index <= CFG_ENTRY_COUNT;
    cfg_wdata <= CFG_DW'(cnt);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_used = (cnt > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : cnt;
  endtask

  // Entry value mix: free, in-range link, any link, chain end, raw
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = '0;
      3:       v = (cur_used > 0) ? $urandom_range(0, cur_used - 1) : '0;
      4:       v = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
      5:       v = $urandom | 32'h0FFF_FFF8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // One random transaction; keep scans rare on large tables
  task automatic random_item();
    op_t                  op;
    logic [CLUSTER_W-1:0] cl;
    int unsigned          r;
    r = $urandom_range(0, 99);
    if (cur_used > 256)
      op = (r < 45) ? OP_READ : (r < 90) ? OP_WRITE : (r < 95) ? OP_EXTEND : OP_COUNT;
    else
      op = (r < 30) ? OP_READ : (r < 60) ? OP_WRITE : (r < 85) ? OP_EXTEND : OP_COUNT;
    if (cur_used == 0 || $urandom_range(0, 9) == 0)
      cl = CLUSTER_W'($urandom_range(0, TABLE_ENTRIES_DEF - 1));
    else
      cl = CLUSTER_W'($urandom_range(0, cur_used - 1));
    send(op, cl, (op == OP_WRITE) ? pick_value() : $urandom);
  endtask

  task automatic run_phase(input logic [FTYPE_W-1:0] ft, input int unsigned cnt,
                           input int unsigned n);
    set_format(ft, cnt);
    repeat (n) random_item();
  endtask

  initial begin
    int c;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Shrink the table in use and load each of its entries, so no read, search
    // or count ever sees an unwritten entry
    set_format(FAT_TYPE_RST, LOAD_ENTRIES);
    for (c = 0; c < LOAD_ENTRIES; c++) send(OP_WRITE, CLUSTER_W'(c), pick_value());

    // Directed: reserved entry, out of range, truncation, end-of-chain bounds
    send(OP_READ, 0, $urandom);
    send(OP_READ, 4095, $urandom);
    send(OP_WRITE, 5, 32'hFFFF_FFFF);
    send(OP_READ, 5, $urandom);
    send(OP_WRITE, 6, 32'h0001_FFF8);
    send(OP_READ, 6, $urandom);
    send(OP_WRITE, 7, 32'hABCD_FFF7);
    send(OP_READ, 7, $urandom);
    send(OP_EXTEND, 7, $urandom);
    send(OP_EXTEND, 5, $urandom);
    send(OP_READ, 5, $urandom);
    send(OP_COUNT, 0, $urandom);

    // FAT12: write refused, extend follows links but cannot allocate
    set_format(FT_FAT12, 8);
    send(OP_WRITE, 3, 32'h0000_0FF8);
    send(OP_READ, 4095, $urandom);
    send(OP_EXTEND, 5, $urandom);
    send(OP_EXTEND, 6, $urandom);
    send(OP_COUNT, 0, $urandom);

    // Empty table: everything out of range, nothing free
    set_format(FT_FAT32, 0);
    send(OP_READ, 0, $urandom);
    send(OP_COUNT, 0, $urandom);
    send(OP_EXTEND, 0, $urandom);

    // Tiny FAT32 table: disk full, then free one entry and allocate it
    set_format(FT_FAT32, 4);
    send(OP_WRITE, 2, 32'hFFFF_FFF8);
    send(OP_WRITE, 3, 32'h0FFF_FFF7);
    send(OP_EXTEND, 2, $urandom);
    send(OP_COUNT, 0, $urandom);
    send(OP_WRITE, 3, 32'h0000_0000);
    send(OP_EXTEND, 2, $urandom);

    // Full and oversized counts: the last entry is in range; touch only it
    set_format(FT_FAT32, 8191);
    send(OP_WRITE, 4095, 32'hF000_0123);
    send(OP_READ, 4095, $urandom);
    send(OP_EXTEND, 4095, $urandom);
    set_format(FT_FAT16, 4096);
    send(OP_READ, 4095, $urandom);

    // Random phases over formats and table sizes
    run_phase(FT_FAT16, 16, 80);
    run_phase(FT_FAT32, 40, 80);
    run_phase(FT_FAT12, 24, 60);
    run_phase(2'd3, 10, 40);
    run_phase(FT_FAT32, 3, 30);
    run_phase(FT_FAT16, 2, 20);
    run_phase(FT_FAT32, LOAD_ENTRIES, 60);
    run_phase(FT_FAT32, 1, 20);
    allow_gaps = 0;
    run_phase(FT_FAT16, 100, 150);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/fcct_pkg.sv
rtl/fcct_dp.sv
rtl/fcct_ctrl.sv
rtl/fat_cluster_chain_table_core.sv
bench/fcct_chain_checker.sv
bench/fat_cluster_chain_table_core_tb.sv
